>>> src/ged_pkg.sv
// Shared widths, sentinel codes, result kinds and bar constants for the
// grouped echo distance average. No dependencies.
`default_nettype none

package ged_pkg;

  localparam int DIST_W = 32;
  localparam int IDX_W  = 16;
  localparam int CNT_W  = 8;
  localparam int SUM_W  = 40;
  localparam int KIND_W = 2;
  localparam int BAR_W  = 23;
  localparam int DVSR_W = 9;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [DIST_W-1:0] LOW_CODE   = 32'h8000_0000;
  localparam logic [DIST_W-1:0] NOISE_CODE = 32'h7FFF_FFFF;

  localparam logic [DIST_W:0]   BAR_OFFSET = 33'd15000;
  localparam logic [DVSR_W-1:0] BAR_STEP   = 9'd500;

  localparam logic [KIND_W-1:0] KIND_AVG   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOW   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NOISE = 2'd2;

endpackage

`default_nettype wire

>>> src/ged_accum.sv
// Bit-serial accumulator: adds one sign-extended distance into the 40-bit
// group sum, one bit per cycle through a serial full adder. Uses ged_pkg.
`default_nettype none

module ged_accum import ged_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     clear,
  input  wire logic                     start,
  input  wire logic signed [DIST_W-1:0] addend,
  output logic                          busy,
  output logic             [SUM_W-1:0]  sum
);

  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  add_r;
  logic              carry_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              sum_bit;
  logic              carry_nxt;

  assign sum_bit   = sum_r[0] ^ add_r[0] ^ carry_r;
  assign carry_nxt = (sum_r[0] & add_r[0]) | (carry_r & (sum_r[0] ^ add_r[0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      carry_r <= 1'b0;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
    end else if (clear) begin
      sum_r <= '0;
    end else if (start) begin
      add_r   <= {{(SUM_W-DIST_W){addend[DIST_W-1]}}, addend};
      carry_r <= 1'b0;
      cnt_r   <= '0;
      busy_r  <= 1'b1;
    end else if (busy_r) begin
      sum_r   <= {sum_bit, sum_r[SUM_W-1:1]};
      add_r   <= {1'b0, add_r[SUM_W-1:1]};
      carry_r <= carry_nxt;
      cnt_r   <= cnt_r + 1'b1;
      if (cnt_r == STEP_W'(SUM_W-1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign sum  = sum_r;

endmodule

`default_nettype wire

>>> src/ged_div.sv
// Bit-serial restoring divider: 40-bit unsigned dividend by a 9-bit divisor,
// one quotient bit per cycle. Shared by the average and bar steps. Uses ged_pkg.
`default_nettype none

module ged_div import ged_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [DVSR_W-1:0] divisor,
  output logic                   busy,
  output logic      [SUM_W-1:0]  quotient
);

  logic [DVSR_W-1:0] rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [DVSR_W-1:0] dvsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic [DVSR_W:0]   rem_sh;
  logic [DVSR_W:0]   rem_diff;
  logic              fits;
  logic [DVSR_W-1:0] rem_nxt;

  assign rem_sh   = {rem_r, quo_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvsr_r};
  assign fits     = rem_sh >= {1'b0, dvsr_r};
  assign rem_nxt  = fits ? rem_diff[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvsr_r <= divisor;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[SUM_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == STEP_W'(SUM_W-1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> src/grouped_echo_distance_average.sv
// Grouped echo distance average: top level with the group control sequencer.
// Uses ged_pkg, ged_accum and ged_div.
//
// Usage: echoes enter on the in_ channel (valid/ready) with their point index
// and an end-of-scan flag. The cfg_ channel writes group_size; the user must
// write it only while the block is idle, which the block does not enforce. The
// cfg_ channel is always ready. Echoes are grouped by group_size (zero acts as
// one); low-signal and noise codes count as echoes but stay out of the sum. A
// group closes when full or on the end-of-scan echo, and one item leaves on the
// out_ channel with point index, valid count, kind, average, bar length. Timing:
// a sentinel echo that closes no group passes S_ACC straight back to idle; a
// valid echo waits in S_ACC for the bit-serial 40-bit add. A closing echo adds
// up to two passes of the shared serial divider (average, then bar length).
// The output register holds a finished item while the next echo is accepted;
// if the receiver stalls and another item is ready, the block holds it and
// stops accepting until out_ready frees the register.
// Reset: group_size returns to 1, the group is emptied, out_valid drops.
`default_nettype none

module grouped_echo_distance_average import ged_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DIST_W-1:0] in_distance,
  input  wire logic        [IDX_W-1:0]  in_point_index,
  input  wire logic                     in_last_of_scan,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic             [IDX_W-1:0]  out_point_index_out,
  output logic             [CNT_W-1:0]  out_valid_count,
  output logic             [KIND_W-1:0] out_kind,
  output logic signed      [DIST_W-1:0] out_average,
  output logic             [BAR_W-1:0]  out_bar_length,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic        [CNT_W-1:0]  cfg_group_size
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ACC      = 3'd1;
  localparam logic [2:0] S_DIV_AVG  = 3'd2;
  localparam logic [2:0] S_BAR_PREP = 3'd3;
  localparam logic [2:0] S_DIV_BAR  = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;

  logic [2:0]               state_r;
  logic [CNT_W-1:0]         group_size_r;
  logic [CNT_W-1:0]         echo_count_r;
  logic [CNT_W-1:0]         valid_total_r;
  logic                     last_low_r;
  logic                     close_r;
  logic [IDX_W-1:0]         pidx_r;
  logic                     neg_r;
  logic signed [DIST_W-1:0] avg_r;
  logic [BAR_W-1:0]         bar_r;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_pidx_r;
  logic [CNT_W-1:0]         out_count_r;
  logic [KIND_W-1:0]        out_kind_r;
  logic signed [DIST_W-1:0] out_avg_r;
  logic [BAR_W-1:0]         out_bar_r;

  logic                     in_fire;
  logic                     is_low;
  logic                     is_noise;
  logic                     is_valid;
  logic [CNT_W-1:0]         count_inc;
  logic                     out_free;
  logic                     emit_fire;

  logic                     acc_start;
  logic                     acc_busy;
  logic [SUM_W-1:0]         acc_sum;
  logic [SUM_W-1:0]         sum_mag;

  logic                     div_start;
  logic                     div_busy;
  logic [SUM_W-1:0]         div_dividend;
  logic [DVSR_W-1:0]        div_divisor;
  logic [SUM_W-1:0]         div_quo;
  logic [SUM_W-1:0]         quo_signed;
  logic [DIST_W:0]          bar_diff;
  logic                     bar_pos;
  logic [KIND_W-1:0]        kind_sel;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign is_low    = (in_distance == LOW_CODE);
  assign is_noise  = (in_distance == NOISE_CODE);
  assign is_valid  = !is_low && !is_noise;
  assign count_inc = echo_count_r + 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign emit_fire = (state_r == S_EMIT) && out_free;
  assign cfg_ready = 1'b1;

  assign sum_mag    = acc_sum[SUM_W-1] ? (~acc_sum + 1'b1) : acc_sum;
  assign quo_signed = neg_r ? (~div_quo + 1'b1) : div_quo;
  assign bar_diff   = {avg_r[DIST_W-1], avg_r} - BAR_OFFSET;
  assign bar_pos    = !bar_diff[DIST_W] && (bar_diff != '0);

  assign acc_start = in_fire && is_valid;
  assign div_start = ((state_r == S_ACC) && !acc_busy && close_r && (valid_total_r != '0))
                  || ((state_r == S_BAR_PREP) && bar_pos);
  assign div_dividend = (state_r == S_ACC) ? sum_mag
                                           : {{(SUM_W-DIST_W-1){1'b0}}, bar_diff};
  assign div_divisor  = (state_r == S_ACC) ? {1'b0, valid_total_r} : BAR_STEP;

  assign kind_sel = (valid_total_r != '0) ? KIND_AVG : (last_low_r ? KIND_LOW : KIND_NOISE);

  ged_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (emit_fire),
    .start  (acc_start),
    .addend (in_distance),
    .busy   (acc_busy),
    .sum    (acc_sum)
  );

  ged_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      group_size_r <= cfg_group_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      echo_count_r  <= '0;
      valid_total_r <= '0;
      last_low_r    <= 1'b0;
      close_r       <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            echo_count_r <= count_inc;
            pidx_r       <= in_point_index;
            close_r      <= (count_inc >= group_size_r) || in_last_of_scan;
            if (is_valid) begin
              valid_total_r <= valid_total_r + 1'b1;
            end else if (valid_total_r == '0) begin
              last_low_r <= is_low;
            end
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (!acc_busy) begin
            neg_r <= acc_sum[SUM_W-1];
            if (!close_r) begin
              state_r <= S_IDLE;
            end else if (valid_total_r == '0) begin
              avg_r   <= '0;
              bar_r   <= '0;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_DIV_AVG;
            end
          end
        end
        S_DIV_AVG: begin
          if (!div_busy) begin
            avg_r   <= quo_signed[DIST_W-1:0];
            state_r <= S_BAR_PREP;
          end
        end
        S_BAR_PREP: begin
          if (bar_pos) begin
            state_r <= S_DIV_BAR;
          end else begin
            bar_r   <= '0;
            state_r <= S_EMIT;
          end
        end
        S_DIV_BAR: begin
          if (!div_busy) begin
            bar_r   <= div_quo[BAR_W-1:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            echo_count_r  <= '0;
            valid_total_r <= '0;
            last_low_r    <= 1'b0;
            close_r       <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
      out_pidx_r  <= pidx_r;
      out_count_r <= valid_total_r;
      out_kind_r  <= kind_sel;
      out_avg_r   <= avg_r;
      out_bar_r   <= bar_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_point_index_out = out_pidx_r;
  assign out_valid_count     = out_count_r;
  assign out_kind            = out_kind_r;
  assign out_average         = out_avg_r;
  assign out_bar_length      = out_bar_r;

endmodule

`default_nettype wire
